### design/assert_macros.svh
// Assertion macros used by the core design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("%m: forbidden condition seen");

// The antecedent must always bring the consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication failed");

`endif

### design/ccs_pkg.sv
// Types and character codes for the comment stripper and line normaliser.
package ccs_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_EOL  = 1'b1;

	// Output buffer depth and its derived widths.
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic in_string;
		logic escape_pending;
		logic in_block_comment;
		logic star_seen;
		logic slash_pending;
		logic in_line_comment;
		logic line_has_text;
	} ccs_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_out;
		logic       last;
	} ccs_item_t;

	// Up to two result words produced by one input word.
	typedef struct packed {
		logic [1:0] count;
		ccs_item_t  item1;
		ccs_item_t  item0;
	} ccs_result_t;

endpackage

### design/ccs_in_if.sv
// Input channel: one source byte or an end-of-input marker per word.
interface ccs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source (output valid, output byte_in, output end_of_input, input ready);
	modport sink (input valid, input byte_in, input end_of_input, output ready);
endinterface

### design/ccs_out_if.sv
// Output channel: one character or end-of-line word per transfer.
interface ccs_out_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_out;
	logic       last;

	modport source (output valid, output kind, output byte_out, output last, input ready);
	modport sink (input valid, input kind, input byte_out, input last, output ready);
endinterface

### design/c_comment_strip_line_normalizer_core.sv
// Top level of the C comment stripper and line normaliser.
// Usage:
//   in_ch carries one source byte per word, or an end-of-input marker with
//   end_of_input high (byte_in then ignored). out_ch carries character words
//   (kind 0) and end-of-line words (kind 1, byte 0); last marks the final
//   word caused by one input word. An input word causes zero, one or two
//   output words. A word is moved when valid and ready are both high.
// Path: a word accepted sits in the input register, is scanned from there
//   and, once two buffer slots are free, is written to a four-word output
//   buffer, from which its results are taken.
// Throughput: one input word per cycle and one output word per cycle while
//   the receiver holds ready high and the buffer has room; the output port's
//   single word per cycle sets the pace; words with two results slow the input.
// Stall: while the receiver holds ready low the buffer fills; the input
//   register waits once fewer than two buffer slots are free, and then
//   in_ch.ready falls. Nothing is dropped.
// Reset: arst_n clears the lexical state, the input register's valid flag
//   and the buffer pointers and count at once; in_ch.ready is high on release.
`include "assert_macros.svh"

module c_comment_strip_line_normalizer_core (
	input  logic           clk,
	input  logic           arst_n,
	ccs_in_if.sink         in_ch,
	ccs_out_if.source      out_ch
);

	logic                             valid_s1;
	logic [7:0]                       byte_s1;
	logic                             eoi_s1;
	ccs_pkg::ccs_state_t              state_q;
	ccs_pkg::ccs_state_t              state_nxt;
	ccs_pkg::ccs_result_t             res;
	ccs_pkg::ccs_item_t               mem_q [ccs_pkg::FIFO_DEPTH];
	logic [ccs_pkg::PTR_W-1:0]        wr_ptr_q;
	logic [ccs_pkg::PTR_W-1:0]        rd_ptr_q;
	logic [ccs_pkg::CNT_W-1:0]        count_q;
	logic                             advance;
	logic                             pop;
	logic [ccs_pkg::CNT_W-1:0]        push_cnt;

	ccs_step u_step (
		.cur          (state_q),
		.byte_in      (byte_s1),
		.end_of_input (eoi_s1),
		.nxt          (state_nxt),
		.res          (res)
	);

	// The scanned word moves on only when both of its possible results fit.
	assign advance  = valid_s1 &&
		(count_q <= ccs_pkg::CNT_W'(ccs_pkg::FIFO_DEPTH - 2));
	assign in_ch.ready = !valid_s1 || advance;
	assign pop      = out_ch.valid && out_ch.ready;
	assign push_cnt = advance ? ccs_pkg::CNT_W'(res.count) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.byte_in;
			eoi_s1  <= in_ch.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance) begin
				state_q  <= state_nxt;
				wr_ptr_q <= wr_ptr_q + ccs_pkg::PTR_W'(res.count);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + push_cnt - ccs_pkg::CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.count != 2'd0) begin
			mem_q[wr_ptr_q] <= res.item0;
		end
		if (advance && res.count == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= res.item1;
		end
	end

	assign out_ch.valid    = (count_q != '0);
	assign out_ch.kind     = mem_q[rd_ptr_q].kind;
	assign out_ch.byte_out = mem_q[rd_ptr_q].byte_out;
	assign out_ch.last     = mem_q[rd_ptr_q].last;

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > ccs_pkg::CNT_W'(ccs_pkg::FIFO_DEPTH))
	`ASSERT_NEVER(a_string_in_comment, clk, arst_n, state_q.in_string && state_q.in_block_comment)
	`ASSERT_IMPLIES(a_slash_outside_string, clk, arst_n, state_q.slash_pending,
		!state_q.in_string && !state_q.in_line_comment)
	`ASSERT_IMPLIES(a_eol_last, clk, arst_n, out_ch.valid && out_ch.kind, out_ch.last)

endmodule

### design/ccs_step.sv
// Per-byte scanner: next lexical state and the result words for one input.
module ccs_step (
	input  ccs_pkg::ccs_state_t  cur,
	input  logic [7:0]           byte_in,
	input  logic                 end_of_input,
	output ccs_pkg::ccs_state_t  nxt,
	output ccs_pkg::ccs_result_t res
);

	logic line_end;
	logic do_plain;
	logic pre_slash;
	logic plain_emit;
	logic is_blank;

	assign line_end = end_of_input || (byte_in == ccs_pkg::CH_NL);
	assign is_blank = (byte_in == ccs_pkg::CH_SPACE) || (byte_in == ccs_pkg::CH_TAB);

	always_comb begin
		nxt        = cur;
		res        = '0;
		do_plain   = 1'b0;
		pre_slash  = 1'b0;
		plain_emit = 1'b0;

		if (line_end) begin
			nxt.in_string       = 1'b0;
			nxt.escape_pending  = 1'b0;
			nxt.slash_pending   = 1'b0;
			nxt.in_line_comment = 1'b0;
			nxt.line_has_text   = 1'b0;
			nxt.star_seen       = 1'b0;
		end else if (cur.in_block_comment) begin
			if (cur.star_seen && byte_in == ccs_pkg::CH_SLASH) begin
				nxt.in_block_comment = 1'b0;
				nxt.star_seen        = 1'b0;
			end else begin
				nxt.star_seen = (byte_in == ccs_pkg::CH_STAR);
			end
		end else if (cur.in_line_comment) begin
			nxt = cur;
		end else if (cur.slash_pending) begin
			nxt.slash_pending = 1'b0;
			if (byte_in == ccs_pkg::CH_SLASH) begin
				nxt.in_line_comment = 1'b1;
			end else if (byte_in == ccs_pkg::CH_STAR) begin
				nxt.in_block_comment = 1'b1;
				nxt.star_seen        = 1'b0;
			end else begin
				// A lone slash is a character; the byte after it is scanned as usual.
				pre_slash         = 1'b1;
				nxt.line_has_text = 1'b1;
				do_plain          = 1'b1;
			end
		end else begin
			do_plain = 1'b1;
		end

		// A slash pending never coexists with a string, so the string flags are current.
		if (do_plain) begin
			if (cur.in_string) begin
				if (cur.escape_pending) begin
					nxt.escape_pending = 1'b0;
					plain_emit         = 1'b1;
				end else if (!is_blank) begin
					plain_emit = 1'b1;
					if (byte_in == ccs_pkg::CH_QUOTE) begin
						nxt.in_string = 1'b0;
					end else if (byte_in == ccs_pkg::CH_BSLASH) begin
						nxt.escape_pending = 1'b1;
					end
				end
			end else if (!is_blank) begin
				if (byte_in == ccs_pkg::CH_SLASH) begin
					nxt.slash_pending = 1'b1;
				end else begin
					plain_emit = 1'b1;
					if (byte_in == ccs_pkg::CH_QUOTE) begin
						nxt.in_string = 1'b1;
					end
				end
			end
			if (plain_emit) begin
				nxt.line_has_text = 1'b1;
			end
		end

		if (line_end) begin
			if (cur.slash_pending) begin
				res.count = 2'd2;
				res.item0 = '{kind: ccs_pkg::KIND_CHAR, byte_out: ccs_pkg::CH_SLASH, last: 1'b0};
				res.item1 = '{kind: ccs_pkg::KIND_EOL, byte_out: 8'h00, last: 1'b1};
			end else if (cur.line_has_text) begin
				res.count = 2'd1;
				res.item0 = '{kind: ccs_pkg::KIND_EOL, byte_out: 8'h00, last: 1'b1};
			end
		end else if (pre_slash && plain_emit) begin
			res.count = 2'd2;
			res.item0 = '{kind: ccs_pkg::KIND_CHAR, byte_out: ccs_pkg::CH_SLASH, last: 1'b0};
			res.item1 = '{kind: ccs_pkg::KIND_CHAR, byte_out: byte_in, last: 1'b1};
		end else if (pre_slash) begin
			res.count = 2'd1;
			res.item0 = '{kind: ccs_pkg::KIND_CHAR, byte_out: ccs_pkg::CH_SLASH, last: 1'b1};
		end else if (plain_emit) begin
			res.count = 2'd1;
			res.item0 = '{kind: ccs_pkg::KIND_CHAR, byte_out: byte_in, last: 1'b1};
		end
	end

endmodule

### dv/testbench.sv
// Self-checking testbench for the C comment stripper and line normaliser core.
module testbench;

	localparam int RANDOM_WORDS = 1800;
	localparam int IDLE_LIMIT   = 2000;
	localparam int MAX_PRINTED  = 30;

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
	} src_word_t;

	logic clk = 1'b0;
	logic arst_n;

	ccs_in_if  in_ch();
	ccs_out_if out_ch();

	c_comment_strip_line_normalizer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #10 clk = ~clk;

	src_word_t           source_words[$];
	ccs_pkg::ccs_item_t  expected_words[$];
	ccs_pkg::ccs_item_t  step_words[$];
	ccs_pkg::ccs_state_t lex = '0;
	int                  mismatches = 0;
	int                  out_count = 0;

	// Lexer state and result prediction.
	function automatic void put_word(logic kind, logic [7:0] ch);
		ccs_pkg::ccs_item_t w;
		w.kind = kind;
		w.byte_out = ch;
		w.last = 1'b0;
		step_words.push_back(w);
		if (kind == ccs_pkg::KIND_CHAR)
			lex.line_has_text = 1'b1;
	endfunction

	// A byte outside any comment, with no slash waiting.
	function automatic void plain_char(logic [7:0] ch);
		if (lex.in_string) begin
			if (lex.escape_pending) begin
				lex.escape_pending = 1'b0;
				put_word(ccs_pkg::KIND_CHAR, ch);
			end else if (ch != ccs_pkg::CH_SPACE && ch != ccs_pkg::CH_TAB) begin
				if (ch == ccs_pkg::CH_QUOTE)
					lex.in_string = 1'b0;
				else if (ch == ccs_pkg::CH_BSLASH)
					lex.escape_pending = 1'b1;
				put_word(ccs_pkg::KIND_CHAR, ch);
			end
		end else if (ch == ccs_pkg::CH_SLASH) begin
			lex.slash_pending = 1'b1;
		end else if (ch != ccs_pkg::CH_SPACE && ch != ccs_pkg::CH_TAB) begin
			if (ch == ccs_pkg::CH_QUOTE)
				lex.in_string = 1'b1;
			put_word(ccs_pkg::KIND_CHAR, ch);
		end
	endfunction

	function automatic void strip_step(logic [7:0] ch, logic eoi);
		ccs_pkg::ccs_item_t w;
		step_words.delete();
		if (eoi || ch == ccs_pkg::CH_NL) begin
			if (lex.slash_pending)
				put_word(ccs_pkg::KIND_CHAR, ccs_pkg::CH_SLASH);
			if (lex.line_has_text)
				put_word(ccs_pkg::KIND_EOL, 8'h00);
			lex.in_string = 1'b0;
			lex.escape_pending = 1'b0;
			lex.slash_pending = 1'b0;
			lex.in_line_comment = 1'b0;
			lex.line_has_text = 1'b0;
			lex.star_seen = 1'b0;
		end else if (lex.in_block_comment) begin
			if (lex.star_seen && ch == ccs_pkg::CH_SLASH) begin
				lex.in_block_comment = 1'b0;
				lex.star_seen = 1'b0;
			end else begin
				lex.star_seen = (ch == ccs_pkg::CH_STAR);
			end
		end else if (!lex.in_line_comment) begin
			if (lex.slash_pending) begin
				lex.slash_pending = 1'b0;
				if (ch == ccs_pkg::CH_SLASH) begin
					lex.in_line_comment = 1'b1;
				end else if (ch == ccs_pkg::CH_STAR) begin
					lex.in_block_comment = 1'b1;
					lex.star_seen = 1'b0;
				end else begin
					put_word(ccs_pkg::KIND_CHAR, ccs_pkg::CH_SLASH);
					plain_char(ch);
				end
			end else begin
				plain_char(ch);
			end
		end
		for (int i = 0; i < step_words.size(); i++) begin
			w = step_words[i];
			w.last = (i == step_words.size() - 1);
			expected_words.push_back(w);
		end
	endfunction

	task automatic report(input string msg);
		if (mismatches < MAX_PRINTED)
			$display("%s", msg);
		mismatches++;
	endtask

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Stimulus building.
	task automatic add_word(input logic [7:0] ch, input logic eoi = 1'b0);
		src_word_t w;
		w.data = ch;
		w.eoi = eoi;
		source_words.push_back(w);
	endtask

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] ident_char();
		case ($urandom_range(0, 3))
			0: return 8'h41 + 8'($urandom_range(0, 25));
			1: return 8'h61 + 8'($urandom_range(0, 25));
			2: return 8'h30 + 8'($urandom_range(0, 9));
			default: return 8'h3B;
		endcase
	endfunction

	task automatic add_token();
		int n;
		logic [7:0] ch;
		case ($urandom_range(0, 19)) inside
			[0:5]: begin
				n = $urandom_range(1, 6);
				repeat (n) add_word(ident_char());
			end
			[6:7]: begin
				n = $urandom_range(1, 3);
				repeat (n) add_word($urandom_range(0, 1) ? ccs_pkg::CH_SPACE : ccs_pkg::CH_TAB);
			end
			[8:9]: begin
				add_word(ccs_pkg::CH_QUOTE);
				n = $urandom_range(0, 6);
				repeat (n) begin
					case ($urandom_range(0, 9))
						0: add_word(ccs_pkg::CH_SPACE);
						1: add_word(ccs_pkg::CH_TAB);
						2: begin
							add_word(ccs_pkg::CH_BSLASH);
							case ($urandom_range(0, 5))
								0: add_word(ccs_pkg::CH_QUOTE);
								1: add_word(ccs_pkg::CH_SPACE);
								2: add_word(ccs_pkg::CH_BSLASH);
								3: add_word(ccs_pkg::CH_NL);
								default: add_word(rand_byte());
							endcase
						end
						3: add_word(ccs_pkg::CH_SLASH);
						4: add_word(ccs_pkg::CH_STAR);
						default: add_word(ident_char());
					endcase
				end
				if ($urandom_range(0, 9) != 0)
					add_word(ccs_pkg::CH_QUOTE);
			end
			10: begin
				add_word(ccs_pkg::CH_SLASH);
				add_word(ccs_pkg::CH_SLASH);
				n = $urandom_range(0, 8);
				repeat (n) begin
					ch = rand_byte();
					add_word(ch == ccs_pkg::CH_NL ? ccs_pkg::CH_STAR : ch);
				end
				add_word(ccs_pkg::CH_NL);
			end
			11: begin
				add_word(ccs_pkg::CH_SLASH);
				add_word(ccs_pkg::CH_STAR);
				n = $urandom_range(0, 8);
				repeat (n) begin
					case ($urandom_range(0, 9)) inside
						[0:1]: add_word(ccs_pkg::CH_STAR);
						[2:3]: add_word(ccs_pkg::CH_SLASH);
						4: add_word(ccs_pkg::CH_NL);
						5: add_word(ccs_pkg::CH_QUOTE);
						default: add_word(ident_char());
					endcase
				end
				if ($urandom_range(0, 6) != 0) begin
					add_word(ccs_pkg::CH_STAR);
					add_word(ccs_pkg::CH_SLASH);
				end
			end
			12: begin
				add_word(ccs_pkg::CH_SLASH);
				case ($urandom_range(0, 3))
					0: add_word(ccs_pkg::CH_SPACE);
					1: add_word(ccs_pkg::CH_QUOTE);
					2: add_word(ccs_pkg::CH_TAB);
					default: add_word(ident_char());
				endcase
			end
			[13:15]: add_word(ccs_pkg::CH_NL);
			[16:17]: begin
				n = $urandom_range(1, 3);
				repeat (n) add_word(rand_byte());
			end
			18: begin
				case ($urandom_range(0, 3))
					0: add_word(ccs_pkg::CH_BSLASH);
					1: add_word(ccs_pkg::CH_STAR);
					2: add_word(8'h0D);
					default: add_word(8'h00);
				endcase
			end
			default: begin
				if ($urandom_range(0, 3) == 0)
					add_word(rand_byte(), 1'b1);
				else
					add_word(ccs_pkg::CH_NL);
			end
		endcase
	endtask

	initial begin
		int directed;
		arst_n = 1'b0;

		// Blanks dropped, byte extremes kept, string with escaped quote and escaped newline.
		add_word(8'h78); add_word(ccs_pkg::CH_SPACE); add_word(ccs_pkg::CH_TAB);
		add_word(8'h00); add_word(8'hFF); add_word(ccs_pkg::CH_QUOTE);
		add_word(ccs_pkg::CH_SPACE); add_word(ccs_pkg::CH_BSLASH);
		add_word(ccs_pkg::CH_QUOTE); add_word(ccs_pkg::CH_BSLASH); add_word(ccs_pkg::CH_NL);
		// A lone slash before a space, then a slash left waiting at the newline.
		add_word(ccs_pkg::CH_SLASH); add_word(ccs_pkg::CH_SPACE);
		add_word(ccs_pkg::CH_SLASH); add_word(ccs_pkg::CH_NL);
		// Slash-star-slash keeps the comment open, which also spans the newline.
		add_word(ccs_pkg::CH_SLASH); add_word(ccs_pkg::CH_STAR);
		add_word(ccs_pkg::CH_SLASH); add_word(8'h61); add_word(ccs_pkg::CH_NL);
		// Close, then a lone slash before a quote opens a string; end of input ends it.
		add_word(ccs_pkg::CH_STAR); add_word(ccs_pkg::CH_SLASH);
		add_word(ccs_pkg::CH_SLASH); add_word(ccs_pkg::CH_QUOTE);
		add_word(8'hA5, 1'b1);
		// Backslash outside a string, then a line comment cut by end of input.
		add_word(ccs_pkg::CH_BSLASH); add_word(ccs_pkg::CH_SLASH);
		add_word(ccs_pkg::CH_SLASH); add_word(8'h71);
		add_word(8'h5A, 1'b1);
		directed = source_words.size();

		while (source_words.size() < directed + RANDOM_WORDS)
			add_token();
		add_word(rand_byte(), 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		@(negedge clk);
		while (source_words.size() != 0 || in_ch.valid || expected_words.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Sender.
	src_word_t next_word;
	int        send_gap = 0;
	bit        send_calm = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.byte_in <= 8'h00;
			in_ch.end_of_input <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				strip_step(in_ch.byte_in, in_ch.end_of_input);
			if ($urandom_range(0, 150) == 0)
				send_calm = !send_calm;
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (source_words.size() > 0) begin
					next_word = source_words.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.byte_in <= next_word.data;
					in_ch.end_of_input <= next_word.eoi;
					send_gap = pick_gap(send_calm);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-offs so that the buffer fills and the input stalls.
	int   cycle_no = 0;
	int   hold_count = 0;
	logic hold_off = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			cycle_no++;
			if (cycle_no == 400 || cycle_no == 2400)
				hold_count = 200;
			if (hold_count > 0)
				hold_count--;
			hold_off <= (hold_count > 0);
		end
	end

	// Receiver and checker.
	ccs_pkg::ccs_item_t got_word;
	ccs_pkg::ccs_item_t want_word;
	int                 sink_gap = 0;
	bit                 sink_calm = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got_word.kind = out_ch.kind;
				got_word.byte_out = out_ch.byte_out;
				got_word.last = out_ch.last;
				if (expected_words.size() == 0) begin
					report($sformatf("word %0d unexpected: kind %0d byte %02h last %0d",
						out_count, got_word.kind, got_word.byte_out, got_word.last));
				end else begin
					want_word = expected_words.pop_front();
					if (got_word.kind !== want_word.kind
							|| got_word.byte_out !== want_word.byte_out
							|| got_word.last !== want_word.last)
						report($sformatf({"word %0d: got kind %0d byte %02h last %0d, ",
							"wanted kind %0d byte %02h last %0d"}, out_count,
							got_word.kind, got_word.byte_out, got_word.last,
							want_word.kind, want_word.byte_out, want_word.last));
				end
				out_count++;
			end
			if ($urandom_range(0, 150) == 0)
				sink_calm = !sink_calm;
			if (hold_off) begin
				out_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				sink_gap = pick_gap(sink_calm);
			end
		end
	end

	// Watchdog: ends the run when nothing has moved for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

### sim.f
+incdir+design
design/ccs_pkg.sv
design/ccs_in_if.sv
design/ccs_out_if.sv
design/ccs_step.sv
design/c_comment_strip_line_normalizer_core.sv
dv/testbench.sv
